FILE: design/nmea_line_framer_queue_unit_assert.svh
// Assertion macros for the line framer queue checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef NMEA_LINE_FRAMER_QUEUE_UNIT_ASSERT_SVH
`define NMEA_LINE_FRAMER_QUEUE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NLFQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NLFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/nlfq_pkg.sv
// Shared types, codes and constants of the line framer queue.
// No dependencies; used by the interfaces, front, queue, back, top level and checker.
package nlfq_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int unsigned LINE_BYTES_DEF  = 64;
    localparam int unsigned QUEUE_DEPTH_DEF = 8;

    // Depth of the queue between the front and the back.
    localparam int unsigned CMD_FIFO_DEPTH = 2;

    // Field widths of the channels.
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned MAXL_W   = 7;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = 3;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_BYTE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

    // Peek addressing modes.
    localparam logic [MODE_W-1:0] PM_ABS  = 2'd0;
    localparam logic [MODE_W-1:0] PM_HEAD = 2'd1;
    localparam logic [MODE_W-1:0] PM_TAIL = 2'd2;

    // Characters the framer reacts to.
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_VTAB   = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FFEED  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_V      = 8'h56;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h54;
    localparam logic [CHAR_W-1:0] CH_G      = 8'h47;

    // Sentence check: offsets of the start, talker and type characters, and the longest length rejected.
    localparam int unsigned VTG_OFS_START  = 0;
    localparam int unsigned VTG_OFS_SECOND = 1;
    localparam int unsigned VTG_OFS_V      = 3;
    localparam int unsigned VTG_OFS_T      = 4;
    localparam int unsigned VTG_OFS_G      = 5;
    localparam int unsigned VTG_MIN_LEN    = 6;

    // Classified operation passed from the front to the back.
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_EOL,
        OP_POP,
        OP_PEEK,
        OP_BAD_PEEK
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] data;
        logic              is_space;
        logic [MODE_W-1:0] peek_mode;
        logic [IDX_W-1:0]  peek_index;
        logic [MAXL_W-1:0] max_len;
    } cmd_t;

    // A command together with its valid flag, used on both sides of the queue.
    typedef struct packed {
        logic vld;
        cmd_t cmd;
    } cmd_xfer_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        RS_CHAR     = 2'd0,
        RS_EMPTY    = 2'd1,
        RS_BAD_SLOT = 2'd2
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [CHAR_W-1:0] out_char;
        logic              last;
        logic              is_vtg;
        logic [SLOT_W-1:0] slot_number;
        logic [SLOT_W-1:0] head_slot;
        logic [SLOT_W-1:0] tail_slot;
    } rsp_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_COPY,
        BK_LEN,
        BK_FETCH,
        BK_EMIT
    } back_state_t;

endpackage

FILE: design/nlfq_in_if.sv
// Request channel of the line framer queue: valid, ready and request fields.
// Depends on nlfq_pkg for the field widths.
interface nlfq_in_if;
    logic                           valid;
    logic                           ready;
    logic [nlfq_pkg::REQ_W-1:0]     req_type;
    logic [nlfq_pkg::CHAR_W-1:0]    rx_byte;
    logic [nlfq_pkg::MODE_W-1:0]    peek_mode;
    logic [nlfq_pkg::IDX_W-1:0]     peek_index;
    logic [nlfq_pkg::MAXL_W-1:0]    peek_max_len;

    modport source (
        output valid, req_type, rx_byte, peek_mode, peek_index, peek_max_len,
        input  ready
    );

    modport sink (
        input  valid, req_type, rx_byte, peek_mode, peek_index, peek_max_len,
        output ready
    );
endinterface

FILE: design/nlfq_out_if.sv
// Result channel of the line framer queue: valid, ready and result fields.
// Depends on nlfq_pkg for the field widths.
interface nlfq_out_if;
    logic                           valid;
    logic                           ready;
    logic [nlfq_pkg::STATUS_W-1:0]  status;
    logic [nlfq_pkg::CHAR_W-1:0]    out_char;
    logic                           last;
    logic                           is_vtg;
    logic [nlfq_pkg::SLOT_W-1:0]    slot_number;
    logic [nlfq_pkg::SLOT_W-1:0]    head_slot;
    logic [nlfq_pkg::SLOT_W-1:0]    tail_slot;

    modport source (
        output valid, status, out_char, last, is_vtg, slot_number, head_slot, tail_slot,
        input  ready
    );

    modport sink (
        input  valid, status, out_char, last, is_vtg, slot_number, head_slot, tail_slot,
        output ready
    );
endinterface

FILE: design/nlfq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nlfq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/nlfq_front.sv
// Front end: accepts request items, classifies them and clamps their fields.
// Depends on nlfq_pkg and nlfq_in_if.
module nlfq_front #(
    parameter int unsigned LINE_BYTES  = nlfq_pkg::LINE_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH = nlfq_pkg::QUEUE_DEPTH_DEF
) (
    nlfq_in_if.sink              cmd,
    input  logic                 full,
    output nlfq_pkg::cmd_xfer_t  push
);

    nlfq_pkg::cmd_t c;
    logic           keep;

    // Classify the request and tidy its fields for the back end.
    always_comb
    begin
        c            = '0;
        keep         = 1'b1;
        c.data       = cmd.rx_byte;
        c.peek_mode  = cmd.peek_mode;
        c.peek_index = cmd.peek_index;
        c.is_space   = (cmd.rx_byte == nlfq_pkg::CH_SPACE) ||
                       (cmd.rx_byte == nlfq_pkg::CH_TAB)   ||
                       (cmd.rx_byte == nlfq_pkg::CH_VTAB)  ||
                       (cmd.rx_byte == nlfq_pkg::CH_FFEED);

        // A peek length of zero means one; the length never exceeds a line.
        if (cmd.peek_max_len == '0)
        begin
            c.max_len = nlfq_pkg::MAXL_W'(1);
        end
        else if (cmd.peek_max_len > nlfq_pkg::MAXL_W'(LINE_BYTES))
        begin
            c.max_len = nlfq_pkg::MAXL_W'(LINE_BYTES);
        end
        else
        begin
            c.max_len = cmd.peek_max_len;
        end

        case (cmd.req_type)
            nlfq_pkg::REQ_BYTE:
            begin
                if ((cmd.rx_byte == nlfq_pkg::CH_CR) || (cmd.rx_byte == nlfq_pkg::CH_LF))
                begin
                    c.op = nlfq_pkg::OP_EOL;
                end
                else
                begin
                    c.op = nlfq_pkg::OP_CHAR;
                end
            end
            nlfq_pkg::REQ_POP:
            begin
                c.op = nlfq_pkg::OP_POP;
            end
            nlfq_pkg::REQ_PEEK:
            begin
                case (cmd.peek_mode)
                    nlfq_pkg::PM_ABS:
                    begin
                        if (7'(cmd.peek_index) >= 7'(QUEUE_DEPTH))
                        begin
                            c.op = nlfq_pkg::OP_BAD_PEEK;
                        end
                        else
                        begin
                            c.op = nlfq_pkg::OP_PEEK;
                        end
                    end
                    nlfq_pkg::PM_HEAD,
                    nlfq_pkg::PM_TAIL:
                    begin
                        c.op = nlfq_pkg::OP_PEEK;
                    end
                    default:
                    begin
                        c.op = nlfq_pkg::OP_BAD_PEEK;
                    end
                endcase
            end
            default:
            begin
                // Unknown request: taken and dropped.
                keep = 1'b0;
            end
        endcase
    end

    assign cmd.ready = !full;
    assign push.vld  = cmd.valid && !full && keep;
    assign push.cmd  = c;

endmodule

FILE: design/nlfq_cmd_fifo.sv
// Short command queue between the front and the back end.
// Depends on nlfq_pkg for the command type and depth.
module nlfq_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nlfq_pkg::cmd_xfer_t  push,
    output logic                 full,
    input  logic                 pop,
    output nlfq_pkg::cmd_xfer_t  head
);

    localparam int unsigned DEPTH = nlfq_pkg::CMD_FIFO_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    nlfq_pkg::cmd_t entries_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign do_push  = push.vld && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.vld = (count_reg != '0);
    assign head.cmd = entries_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

FILE: design/nlfq_back.sv
// Back end: owns the line buffer, the message ring and the result register.
// Depends on nlfq_pkg, nlfq_out_if and nlfq_ram.
module nlfq_back #(
    parameter int unsigned LINE_BYTES  = nlfq_pkg::LINE_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH = nlfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nlfq_pkg::cmd_xfer_t  head,
    output logic                 deq,
    nlfq_out_if.source           rsp
);

    localparam int unsigned LW   = $clog2(LINE_BYTES);
    localparam int unsigned SW   = $clog2(QUEUE_DEPTH);
    localparam int unsigned LENW = LW + 1;
    localparam logic [LW-1:0] FILL_LAST = LW'(LINE_BYTES - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(QUEUE_DEPTH - 1);

    // Next slot round the ring.
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + SW'(1);
    endfunction

    // Reduction modulo the ring depth of a value below sixteen times the depth.
    function automatic logic [7:0] mod_depth(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        for (int k = 3; k >= 0; k--)
        begin
            if (int'(r) >= int'(QUEUE_DEPTH << k))
            begin
                r = r - 8'(QUEUE_DEPTH << k);
            end
        end
        return r;
    endfunction

    nlfq_pkg::back_state_t state_reg, state_next;

    logic [LW-1:0]          line_fill_reg, line_fill_next;
    logic [SW-1:0]          rs_reg, rs_next;
    logic [SW-1:0]          ws_reg, ws_next;
    logic [QUEUE_DEPTH-1:0] len_valid_reg, len_valid_next;
    logic [LW-1:0]          cnt_reg, cnt_next;
    logic                   wr_vld_reg, wr_vld_next;
    logic [LW-1:0]          wr_off_reg, wr_off_next;
    logic [7:0]             c0_reg, c0_next;
    logic                   vtg_ok_reg, vtg_ok_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic                   is_pop_reg, is_pop_next;
    logic [LW:0]            max_len_reg, max_len_next;
    logic [LW-1:0]          len_reg, len_next;
    logic                   vtg_reg, vtg_next;
    logic [LW:0]            count_reg, count_next;
    logic                   out_vld_reg, out_vld_next;
    nlfq_pkg::rsp_t         out_reg, out_next;

    logic                line_we, line_re;
    logic [7:0]          line_rdata;
    logic                store_we, store_re;
    logic [7:0]          store_rdata;
    logic                len_we, len_re;
    logic [SW-1:0]       len_raddr;
    logic [LENW-1:0]     len_wdata, len_rdata;

    logic                out_free;
    logic                is_last;
    logic                copy_done;
    logic [SW-1:0]       peek_slot;
    logic [7:0]          tail_sum;
    logic                ok_v;
    logic [LENW-1:0]     len_word;
    logic [LW:0]         total;

    assign out_free  = !out_vld_reg || rsp.ready;
    assign is_last   = ((LW+1)'(cnt_reg) + (LW+1)'(1)) == count_reg;
    assign copy_done = (cnt_reg == line_fill_reg);

    // Slot addressed by a peek, from the absolute index, the head or the tail.
    always_comb
    begin
        tail_sum = 8'(ws_reg) + 8'(QUEUE_DEPTH) - mod_depth(8'(head.cmd.peek_index));
        if (tail_sum >= 8'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - 8'(QUEUE_DEPTH);
        end
        case (head.cmd.peek_mode)
            nlfq_pkg::PM_ABS:
            begin
                peek_slot = SW'(head.cmd.peek_index);
            end
            nlfq_pkg::PM_HEAD:
            begin
                peek_slot = SW'(mod_depth(8'(rs_reg) + 8'(head.cmd.peek_index)));
            end
            nlfq_pkg::PM_TAIL:
            begin
                peek_slot = SW'(tail_sum);
            end
            default:
            begin
                peek_slot = '0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nlfq_pkg::BK_IDLE:
            begin
                if (head.vld)
                begin
                    case (head.cmd.op)
                        nlfq_pkg::OP_EOL:
                        begin
                            state_next = nlfq_pkg::BK_COPY;
                        end
                        nlfq_pkg::OP_POP:
                        begin
                            if (rs_reg != ws_reg)
                            begin
                                state_next = nlfq_pkg::BK_LEN;
                            end
                        end
                        nlfq_pkg::OP_PEEK:
                        begin
                            state_next = nlfq_pkg::BK_LEN;
                        end
                        default:
                        begin
                            state_next = nlfq_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            nlfq_pkg::BK_COPY:
            begin
                if (copy_done)
                begin
                    state_next = nlfq_pkg::BK_IDLE;
                end
            end
            nlfq_pkg::BK_LEN:
            begin
                state_next = nlfq_pkg::BK_FETCH;
            end
            nlfq_pkg::BK_FETCH:
            begin
                state_next = nlfq_pkg::BK_EMIT;
            end
            nlfq_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? nlfq_pkg::BK_IDLE : nlfq_pkg::BK_FETCH;
                end
            end
            default:
            begin
                state_next = nlfq_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and the result register.
    always_comb
    begin
        line_fill_next = line_fill_reg;
        rs_next        = rs_reg;
        ws_next        = ws_reg;
        len_valid_next = len_valid_reg;
        cnt_next       = cnt_reg;
        wr_vld_next    = 1'b0;
        wr_off_next    = wr_off_reg;
        c0_next        = c0_reg;
        vtg_ok_next    = vtg_ok_reg;
        slot_next      = slot_reg;
        is_pop_next    = is_pop_reg;
        max_len_next   = max_len_reg;
        len_next       = len_reg;
        vtg_next       = vtg_reg;
        count_next     = count_reg;
        out_vld_next   = out_vld_reg && !rsp.ready;
        out_next       = out_reg;
        deq            = 1'b0;
        line_we        = 1'b0;
        line_re        = 1'b0;
        store_we       = 1'b0;
        store_re       = 1'b0;
        len_we         = 1'b0;
        len_re         = 1'b0;
        len_raddr      = rs_reg;
        ok_v           = vtg_ok_reg;
        len_word       = '0;
        total          = '0;
        len_wdata      = '0;

        case (state_reg)
            nlfq_pkg::BK_IDLE:
            begin
                if (head.vld)
                begin
                    case (head.cmd.op)
                        nlfq_pkg::OP_CHAR:
                        begin
                            // Leading whitespace is skipped; a full line is thrown away.
                            deq = 1'b1;
                            if ((line_fill_reg != '0) || !head.cmd.is_space)
                            begin
                                line_we        = 1'b1;
                                line_fill_next = (line_fill_reg == FILL_LAST) ? '0 :
                                                 line_fill_reg + LW'(1);
                            end
                        end
                        nlfq_pkg::OP_EOL:
                        begin
                            // Drop the oldest message when the ring is full.
                            deq = 1'b1;
                            if (slot_inc(ws_reg) == rs_reg)
                            begin
                                rs_next = slot_inc(rs_reg);
                            end
                            cnt_next    = '0;
                            vtg_ok_next = 1'b0;
                        end
                        nlfq_pkg::OP_POP:
                        begin
                            if (rs_reg == ws_reg)
                            begin
                                if (out_free)
                                begin
                                    deq                  = 1'b1;
                                    out_vld_next         = 1'b1;
                                    out_next.status      = nlfq_pkg::RS_EMPTY;
                                    out_next.out_char    = '0;
                                    out_next.last        = 1'b1;
                                    out_next.is_vtg      = 1'b0;
                                    out_next.slot_number = '0;
                                    out_next.head_slot   = nlfq_pkg::SLOT_W'(rs_reg);
                                    out_next.tail_slot   = nlfq_pkg::SLOT_W'(ws_reg);
                                end
                            end
                            else
                            begin
                                deq         = 1'b1;
                                len_re      = 1'b1;
                                len_raddr   = rs_reg;
                                slot_next   = rs_reg;
                                rs_next     = slot_inc(rs_reg);
                                is_pop_next = 1'b1;
                            end
                        end
                        nlfq_pkg::OP_PEEK:
                        begin
                            deq          = 1'b1;
                            len_re       = 1'b1;
                            len_raddr    = peek_slot;
                            slot_next    = peek_slot;
                            is_pop_next  = 1'b0;
                            max_len_next = (LW+1)'(head.cmd.max_len);
                        end
                        nlfq_pkg::OP_BAD_PEEK:
                        begin
                            if (out_free)
                            begin
                                deq                  = 1'b1;
                                out_vld_next         = 1'b1;
                                out_next.status      = nlfq_pkg::RS_BAD_SLOT;
                                out_next.out_char    = '0;
                                out_next.last        = 1'b1;
                                out_next.is_vtg      = 1'b0;
                                out_next.slot_number = '0;
                                out_next.head_slot   = nlfq_pkg::SLOT_W'(rs_reg);
                                out_next.tail_slot   = nlfq_pkg::SLOT_W'(ws_reg);
                            end
                        end
                        default:
                        begin
                            deq = 1'b1;
                        end
                    endcase
                end
            end
            nlfq_pkg::BK_COPY:
            begin
                // Line buffer read, then the ring write of that character in the cycle after.
                line_re  = !copy_done;
                store_we = wr_vld_reg;

                // Sentence check on the characters as they are copied.
                if (wr_vld_reg)
                begin
                    if (wr_off_reg == LW'(nlfq_pkg::VTG_OFS_START))
                    begin
                        c0_next = line_rdata;
                        ok_v    = (line_rdata == nlfq_pkg::CH_DOLLAR) ||
                                  (line_rdata == nlfq_pkg::CH_BANG);
                    end
                    else if (wr_off_reg == LW'(nlfq_pkg::VTG_OFS_SECOND))
                    begin
                        ok_v = vtg_ok_reg && (line_rdata != c0_reg);
                    end
                    else if (wr_off_reg == LW'(nlfq_pkg::VTG_OFS_V))
                    begin
                        ok_v = vtg_ok_reg && (line_rdata == nlfq_pkg::CH_V);
                    end
                    else if (wr_off_reg == LW'(nlfq_pkg::VTG_OFS_T))
                    begin
                        ok_v = vtg_ok_reg && (line_rdata == nlfq_pkg::CH_T);
                    end
                    else if (wr_off_reg == LW'(nlfq_pkg::VTG_OFS_G))
                    begin
                        ok_v = vtg_ok_reg && (line_rdata == nlfq_pkg::CH_G);
                    end
                end
                vtg_ok_next = ok_v;

                if (!copy_done)
                begin
                    wr_vld_next = 1'b1;
                    wr_off_next = cnt_reg;
                    cnt_next    = cnt_reg + LW'(1);
                end
                else
                begin
                    // Last write lands now: commit length, flag and write slot.
                    len_we                 = 1'b1;
                    len_wdata              = {ok_v && (line_fill_reg > LW'(nlfq_pkg::VTG_MIN_LEN)),
                                              line_fill_reg};
                    len_valid_next[ws_reg] = 1'b1;
                    ws_next                = slot_inc(ws_reg);
                    line_fill_next         = '0;
                end
            end
            nlfq_pkg::BK_LEN:
            begin
                // Slots never written read as empty messages.
                len_word   = len_valid_reg[slot_reg] ? len_rdata : '0;
                len_next   = len_word[LW-1:0];
                vtg_next   = is_pop_reg && len_word[LW];
                total      = (LW+1)'(len_word[LW-1:0]) + (LW+1)'(1);
                count_next = (!is_pop_reg && (total > max_len_reg)) ? max_len_reg : total;
                cnt_next   = '0;
            end
            nlfq_pkg::BK_FETCH:
            begin
                store_re = 1'b1;
            end
            nlfq_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next         = 1'b1;
                    out_next.status      = nlfq_pkg::RS_CHAR;
                    out_next.out_char    = (cnt_reg < len_reg) ? store_rdata : '0;
                    out_next.last        = is_last;
                    out_next.is_vtg      = vtg_reg;
                    out_next.slot_number = nlfq_pkg::SLOT_W'(slot_reg);
                    out_next.head_slot   = nlfq_pkg::SLOT_W'(rs_reg);
                    out_next.tail_slot   = nlfq_pkg::SLOT_W'(ws_reg);
                    if (!is_last)
                    begin
                        cnt_next = cnt_reg + LW'(1);
                    end
                end
            end
            default:
            begin
                deq = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nlfq_pkg::BK_IDLE;
            line_fill_reg <= '0;
            rs_reg        <= '0;
            ws_reg        <= '0;
            len_valid_reg <= '0;
            wr_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_fill_reg <= line_fill_next;
            rs_reg        <= rs_next;
            ws_reg        <= ws_next;
            len_valid_reg <= len_valid_next;
            wr_vld_reg    <= wr_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        wr_off_reg  <= wr_off_next;
        c0_reg      <= c0_next;
        vtg_ok_reg  <= vtg_ok_next;
        slot_reg    <= slot_next;
        is_pop_reg  <= is_pop_next;
        max_len_reg <= max_len_next;
        len_reg     <= len_next;
        vtg_reg     <= vtg_next;
        count_reg   <= count_next;
        out_reg     <= out_next;
    end

    // Line under construction.
    nlfq_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_fill_reg),
        .wdata (head.cmd.data),
        .re    (line_re),
        .raddr (cnt_reg),
        .rdata (line_rdata)
    );

    // Message ring, one row of 2**LW characters per slot.
    nlfq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH << LW)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr ({ws_reg, wr_off_reg}),
        .wdata (line_rdata),
        .re    (store_re),
        .raddr ({slot_reg, cnt_reg}),
        .rdata (store_rdata)
    );

    // Per-slot length and sentence flag.
    nlfq_ram #(
        .WIDTH (LENW),
        .DEPTH (QUEUE_DEPTH)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (ws_reg),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.out_char    = out_reg.out_char;
    assign rsp.last        = out_reg.last;
    assign rsp.is_vtg      = out_reg.is_vtg;
    assign rsp.slot_number = out_reg.slot_number;
    assign rsp.head_slot   = out_reg.head_slot;
    assign rsp.tail_slot   = out_reg.tail_slot;

endmodule

FILE: design/nmea_line_framer_queue_unit.sv
// Top level of the line framer queue: front end, command queue and back end.
// Depends on nlfq_pkg, nlfq_in_if, nlfq_out_if, nlfq_front, nlfq_cmd_fifo, nlfq_back.
//
//   Channel   Direction   Item
//   cmd       in          received byte, pop request or peek request
//   rsp       out         one message character, or one status result
//
// An end of line copies the line from the line buffer into the ring over one memory port.
// A pop or peek reads the slot length, then per character a ring read and then the result
// register. Up to two requests wait in the queue between front and back.
// Reset clears pointers and per-slot valid bits at once; there is no clearing pass.
// A stalled result channel holds the back end, while the front keeps filling the queue.
module nmea_line_framer_queue_unit #(
    parameter int unsigned LINE_BYTES  = nlfq_pkg::LINE_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH = nlfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    nlfq_in_if.sink     cmd,
    nlfq_out_if.source  rsp
);

    nlfq_pkg::cmd_xfer_t push;
    nlfq_pkg::cmd_xfer_t head;
    logic                full;
    logic                deq;

    // Classification of incoming items.
    nlfq_front #(
        .LINE_BYTES  (LINE_BYTES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .cmd  (cmd),
        .full (full),
        .push (push)
    );

    // Queue decoupling the two halves.
    nlfq_cmd_fifo u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (deq),
        .head  (head)
    );

    // Line building, ring management and result generation.
    nlfq_back #(
        .LINE_BYTES  (LINE_BYTES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .deq   (deq),
        .rsp   (rsp)
    );

endmodule

FILE: design/nlfq_checker.sv
// Port-level checker for the line framer queue, bound to the top level.
// Depends on nlfq_pkg and nmea_line_framer_queue_unit_assert.svh.
`include "nmea_line_framer_queue_unit_assert.svh"

module nlfq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic [7:0] out_char,
    input logic       last,
    input logic       is_vtg,
    input logic [2:0] slot_number,
    input logic [2:0] head_slot,
    input logic [2:0] tail_slot
);

    // A stalled result keeps its contents.
    `NLFQ_ASSERT_NEXT(a_rsp_hold,
        rsp_valid && !rsp_ready,
        rsp_valid && $stable(out_char) && $stable(last) && $stable(is_vtg) && $stable(status),
        "result changed while stalled")

    // Within a run every item is a character from the same slot.
    `NLFQ_ASSERT_NEXT(a_run_slot,
        rsp_valid && rsp_ready && !last,
        !rsp_valid || ((status == nlfq_pkg::RS_CHAR) && $stable(slot_number)),
        "run changed slot or status")

    // The ring pointers do not move during a run.
    `NLFQ_ASSERT_NEXT(a_run_ptrs,
        rsp_valid && rsp_ready && !last,
        !rsp_valid || ($stable(head_slot) && $stable(tail_slot)),
        "ring pointers moved within a run")

    // An empty queue report shows equal head and tail.
    `NLFQ_ASSERT_SAME(a_empty_ptrs,
        rsp_valid && (status == nlfq_pkg::RS_EMPTY),
        (head_slot == tail_slot) && last,
        "empty report with unequal pointers")

endmodule

bind nmea_line_framer_queue_unit nlfq_checker u_nlfq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .out_char    (rsp.out_char),
    .last        (rsp.last),
    .is_vtg      (rsp.is_vtg),
    .slot_number (rsp.slot_number),
    .head_slot   (rsp.head_slot),
    .tail_slot   (rsp.tail_slot)
);
